@@ sv/nearest_centroid_probe_select_core_defines.svh @@
// Assertion macros shared by the checker files.
`ifndef NEAREST_CENTROID_PROBE_SELECT_CORE_DEFINES_SVH
`define NEAREST_CENTROID_PROBE_SELECT_CORE_DEFINES_SVH
// Check that an antecedent implies a consequent in the next cycle.
`define NCPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define NCPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`endif

@@ sv/ncps_pkg.sv @@
// Shared types and constants of the probe select block.
`timescale 1ns / 1ps
package ncps_pkg;
    localparam int CFG_W  = 7;
    localparam int ID_W   = 6;
    localparam int DIST_W = 38;
    localparam int RES_LIMIT = 64;
    localparam logic [1:0] REG_CENTROIDS = 2'd0;
    localparam logic [1:0] REG_DIMS      = 2'd1;
    localparam logic [1:0] REG_PROBES    = 2'd2;
    localparam logic CMD_CENTROID = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;

    // One sorted entry handed along the cell chain.
    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] sqd;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIST  = 5'b00010,
        ST_FLUSH = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_WAIT  = 5'b10000
    } state_t;
endpackage

@@ sv/ncps_cell.sv @@
// One insertion cell of the sorted chain: keeps the smaller entry, passes the larger on.
`timescale 1ns / 1ps
module ncps_cell (
    input  logic            aclk,
    input  logic            clr,
    input  logic            shift,
    input  ncps_pkg::entry_t in_e,
    input  ncps_pkg::entry_t next_e,
    output ncps_pkg::entry_t held_e,
    output ncps_pkg::entry_t out_e
);
    ncps_pkg::entry_t held_reg, held_next, out_reg, out_next;
    logic in_smaller;

    // Lower distance wins; on equal distance the lower id wins.
    assign in_smaller = in_e.vld && (!held_reg.vld || in_e.sqd < held_reg.sqd ||
                        (in_e.sqd == held_reg.sqd && in_e.id < held_reg.id));

    always_comb begin
        held_next = held_reg;
        out_next  = in_e;
        if (clr) begin
            held_next = '0;
            out_next  = '0;
        end else if (shift) begin
            held_next = next_e;
            out_next  = '0;
        end else if (in_smaller) begin
            held_next = in_e;
            out_next  = held_reg;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    assign held_e = held_reg;
    assign out_e  = out_reg;
endmodule

@@ sv/ncps_mac.sv @@
// Shared squared-difference accumulator fed from the centroid memory.
`timescale 1ns / 1ps
module ncps_mac #(
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          start,
    input  logic                          en,
    input  logic signed [COORD_BITS-1:0]  q,
    input  logic signed [COORD_BITS-1:0]  c,
    output logic [ncps_pkg::DIST_W-1:0]   acc
);
    localparam int DW = COORD_BITS + 1;
    logic signed [DW-1:0] diff_reg, diff_next;
    logic [2*DW-1:0] sq_reg, sq_next;
    logic en_d_reg, start_d_reg, en_d2_reg, start_d2_reg;
    logic [ncps_pkg::DIST_W-1:0] acc_reg, acc_next;

    // Stage one subtract, stage two square, stage three accumulate.
    assign diff_next = DW'(q) - DW'(c);
    assign sq_next = (2*DW)'(diff_reg * diff_reg);
    always_comb begin
        acc_next = acc_reg;
        if (en_d2_reg) begin
            if (start_d2_reg) acc_next = ncps_pkg::DIST_W'(sq_reg);
            else acc_next = acc_reg + ncps_pkg::DIST_W'(sq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg     <= diff_next;
        sq_reg       <= sq_next;
        en_d_reg     <= en;
        start_d_reg  <= start;
        en_d2_reg    <= en_d_reg;
        start_d2_reg <= start_d_reg;
        acc_reg      <= acc_next;
    end
    assign acc = acc_reg;
endmodule

@@ sv/nearest_centroid_probe_select_core.sv @@
// Top level of the nearest centroid probe select block.
//  channel | ports                         | direction
//  s_      | s_valid/s_ready, cmd..last    | in, coordinate words
//  m_      | m_valid/m_ready, id,sqd,last  | out, result words
//  cfg     | cfg_valid/cfg_ready,index,data| in, register writes
// A centroid or non-final query word is only stored. A final query word
// starts a search on one shared multiply-accumulate reading the centroid
// memory one coordinate a cycle, then a flush to drain the pipeline and
// settle the sorting chain, then one result per cycle while m_ready is
// high; s_ready stays low until the last result.
// Reset is synchronous active low; m_valid holds while m_ready is low.
`timescale 1ns / 1ps
module nearest_centroid_probe_select_core #(
    parameter int MAX_CENTROIDS = 64,
    parameter int MAX_DIMS      = 64,
    parameter int COORD_BITS    = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [5:0]                   s_centroid_index,
    input  logic [5:0]                   s_coord_index,
    input  logic signed [15:0]           s_coord_value,
    input  logic                         s_last_coord,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [5:0]                   m_probe_id,
    output logic [37:0]                  m_sq_distance,
    output logic                         m_last_result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [6:0]                   cfg_data
);
    localparam int CW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int DWI = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW = (MAX_CENTROIDS * MAX_DIMS > 1) ?
                        $clog2(MAX_CENTROIDS * MAX_DIMS) : 1;
    localparam int NCELL = (MAX_CENTROIDS < ncps_pkg::RES_LIMIT) ?
                           MAX_CENTROIDS : ncps_pkg::RES_LIMIT;
    localparam int CNTW = ncps_pkg::CFG_W + 1;
    localparam int LAT = 3;

    ncps_pkg::state_t state_reg, state_next;
    logic [ncps_pkg::CFG_W-1:0] nc_cfg_reg, nd_cfg_reg, np_cfg_reg;
    logic [CNTW-1:0] nc_eff, nd_eff, np_eff, np_reg, emit_cnt_reg;
    logic [CNTW-1:0] c_cnt_reg, d_cnt_reg, flush_cnt_reg;
    logic [LAT:0] fin_pipe_reg;
    logic [CW-1:0] id_pipe_reg [LAT+1];
    logic signed [COORD_BITS-1:0] cmem [MAX_CENTROIDS*MAX_DIMS];
    logic signed [COORD_BITS-1:0] qmem [MAX_DIMS];
    logic signed [COORD_BITS-1:0] c_rd_reg, q_rd_reg;
    logic rd_en_reg, rd_start_reg;
    logic [ncps_pkg::DIST_W-1:0] acc;
    logic issue, shift, clr;
    logic s_acc;
    ncps_pkg::entry_t chain_in [NCELL+1];
    ncps_pkg::entry_t held [NCELL+1];
    ncps_pkg::entry_t ins;

    assign s_acc = s_valid && s_ready;
    assign s_ready = (state_reg == ncps_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Saturate configuration into legal ranges.
    always_comb begin
        nc_eff = (nc_cfg_reg == '0) ? CNTW'(1) :
                 (CNTW'(nc_cfg_reg) > CNTW'(NCELL)) ? CNTW'(NCELL) : CNTW'(nc_cfg_reg);
        nd_eff = (nd_cfg_reg == '0) ? CNTW'(1) :
                 (CNTW'(nd_cfg_reg) > CNTW'(MAX_DIMS)) ? CNTW'(MAX_DIMS) :
                 CNTW'(nd_cfg_reg);
        np_eff = (np_cfg_reg == '0) ? CNTW'(1) :
                 (CNTW'(np_cfg_reg) > CNTW'(ncps_pkg::RES_LIMIT)) ?
                 CNTW'(ncps_pkg::RES_LIMIT) : CNTW'(np_cfg_reg);
        if (np_eff > nc_eff) np_eff = nc_eff;
    end

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_cfg_reg <= 7'd64;
            nd_cfg_reg <= 7'd64;
            np_cfg_reg <= 7'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                ncps_pkg::REG_CENTROIDS: nc_cfg_reg <= cfg_data;
                ncps_pkg::REG_DIMS:      nd_cfg_reg <= cfg_data;
                ncps_pkg::REG_PROBES:    np_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Write and read coordinate memories.
    assign issue = (state_reg == ncps_pkg::ST_DIST) && (c_cnt_reg < nc_eff);
    always_ff @(posedge aclk) begin
        if (s_acc && s_cmd == ncps_pkg::CMD_CENTROID &&
            32'(s_centroid_index) < MAX_CENTROIDS && 32'(s_coord_index) < MAX_DIMS)
            cmem[AW'(CW'(s_centroid_index) * MAX_DIMS + DWI'(s_coord_index))] <=
                COORD_BITS'($unsigned(s_coord_value));
        if (s_acc && s_cmd == ncps_pkg::CMD_QUERY && 32'(s_coord_index) < MAX_DIMS)
            qmem[DWI'(s_coord_index)] <= COORD_BITS'($unsigned(s_coord_value));
        c_rd_reg <= cmem[AW'(CW'(c_cnt_reg) * MAX_DIMS + DWI'(d_cnt_reg))];
        q_rd_reg <= qmem[DWI'(d_cnt_reg)];
        rd_en_reg <= issue;
        rd_start_reg <= (d_cnt_reg == '0);
    end

    ncps_mac #(.COORD_BITS(COORD_BITS)) u_mac (
        .aclk(aclk), .start(rd_start_reg), .en(rd_en_reg),
        .q(q_rd_reg), .c(c_rd_reg), .acc(acc)
    );

    // Track centroid completion through the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) fin_pipe_reg <= '0;
        else fin_pipe_reg <= {fin_pipe_reg[LAT-1:0],
                              issue && (d_cnt_reg == nd_eff - CNTW'(1))};
        id_pipe_reg[0] <= CW'(c_cnt_reg);
        for (int i = 1; i <= LAT; i++) id_pipe_reg[i] <= id_pipe_reg[i-1];
    end

    assign ins.vld = fin_pipe_reg[LAT];
    assign ins.id  = ncps_pkg::ID_W'(id_pipe_reg[LAT]);
    assign ins.sqd = acc;

    // Chain of sorting cells.
    assign shift = (state_reg == ncps_pkg::ST_EMIT) && m_ready;
    assign clr = s_acc && s_cmd == ncps_pkg::CMD_QUERY && s_last_coord;
    assign chain_in[0] = ins;
    assign held[NCELL] = '0;
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ncps_cell u_cell (
            .aclk(aclk), .clr(clr), .shift(shift),
            .in_e(chain_in[g]), .next_e(held[g+1]),
            .held_e(held[g]), .out_e(chain_in[g+1])
        );
    end

    // Sequence search, flush and result words.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ncps_pkg::ST_IDLE:  if (clr) state_next = ncps_pkg::ST_DIST;
            ncps_pkg::ST_DIST:  if (!issue) state_next = ncps_pkg::ST_FLUSH;
            ncps_pkg::ST_FLUSH: if (flush_cnt_reg == nc_eff + CNTW'(LAT + 1))
                                    state_next = ncps_pkg::ST_EMIT;
            ncps_pkg::ST_EMIT:  if (shift && emit_cnt_reg == np_reg - CNTW'(1))
                                    state_next = ncps_pkg::ST_IDLE;
            default: state_next = ncps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ncps_pkg::ST_IDLE;
            c_cnt_reg <= '0;
            d_cnt_reg <= '0;
            flush_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            np_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clr) begin
                c_cnt_reg <= '0;
                d_cnt_reg <= '0;
                flush_cnt_reg <= '0;
                emit_cnt_reg <= '0;
                np_reg <= np_eff;
            end
            if (issue) begin
                if (d_cnt_reg == nd_eff - CNTW'(1)) begin
                    d_cnt_reg <= '0;
                    c_cnt_reg <= c_cnt_reg + CNTW'(1);
                end else d_cnt_reg <= d_cnt_reg + CNTW'(1);
            end
            if (state_reg == ncps_pkg::ST_FLUSH) flush_cnt_reg <= flush_cnt_reg + CNTW'(1);
            if (shift) emit_cnt_reg <= emit_cnt_reg + CNTW'(1);
        end
    end

    assign m_valid = (state_reg == ncps_pkg::ST_EMIT);
    assign m_probe_id = held[0].id;
    assign m_sq_distance = held[0].sqd;
    assign m_last_result = (emit_cnt_reg == np_reg - CNTW'(1));
endmodule

@@ sv/ncps_checker.sv @@
// Port-level checker for the probe select block, with its bind.
`timescale 1ns / 1ps
`include "nearest_centroid_probe_select_core_defines.svh"
module ncps_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_last_result,
    input logic [37:0] m_sq_distance
);
    `NCPS_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "input taken during results")
    `NCPS_ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `NCPS_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_last_result, !m_valid, "results after last")
    `NCPS_ASSERT_NEXT(a_sorted, aclk, aresetn, m_valid && m_ready && !m_last_result, m_sq_distance >= $past(m_sq_distance), "results out of order")
endmodule

bind nearest_centroid_probe_select_core ncps_checker u_ncps_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_last_result(m_last_result),
    .m_sq_distance(m_sq_distance)
);

@@ tb/tb_nearest_centroid_probe_select_core.sv @@
// Testbench for the nearest centroid probe select core with a self-checking scoreboard.
`timescale 1ns / 1ps
module tb_nearest_centroid_probe_select_core;

    typedef struct {
        logic [5:0]  id;
        logic [37:0] sqd;
        logic        last;
    } probe_t;

    // Predict probe lists from the coordinate words and compare result words.
    class probe_scoreboard;
        logic signed [15:0] cent[64][64];
        logic signed [15:0] query[64];
        int unsigned        n_cent, n_dims, n_probe;
        probe_t             pending[$];
        int                 errors;

        function new();
            n_cent  = 64;
            n_dims  = 64;
            n_probe = 8;
            errors  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] v);
            case (idx)
                ncps_pkg::REG_CENTROIDS: n_cent  = 32'(v);
                ncps_pkg::REG_DIMS:      n_dims  = 32'(v);
                ncps_pkg::REG_PROBES:    n_probe = 32'(v);
                default: ;
            endcase
        endfunction

        // Buffer the word and, on a final query word, rank the centroids.
        function void note_word(logic cmd, logic [5:0] ci, logic [5:0] di,
                                logic signed [15:0] val, logic last);
            int unsigned nc, nd, np, best;
            longint      sqd[64];
            bit          taken[64];
            longint      diff;
            bit          found;
            probe_t      p;
            if (cmd == ncps_pkg::CMD_CENTROID) begin
                cent[ci][di] = val;
                return;
            end
            query[di] = val;
            if (!last)
                return;
            nc = (n_cent < 1) ? 1 : (n_cent > 64) ? 64 : n_cent;
            nd = (n_dims < 1) ? 1 : (n_dims > 64) ? 64 : n_dims;
            np = (n_probe < 1) ? 1 : (n_probe > 64) ? 64 : n_probe;
            if (np > nc)
                np = nc;
            for (int c = 0; c < nc; c++) begin
                sqd[c]   = 0;
                taken[c] = 0;
                for (int d = 0; d < nd; d++) begin
                    diff = longint'(query[d]) - longint'(cent[c][d]);
                    sqd[c] += diff * diff;
                end
            end
            // Select in ascending distance, lower id wins a tie.
            for (int k = 0; k < np; k++) begin
                found = 0;
                best  = 0;
                for (int c = 0; c < nc; c++) begin
                    if (!taken[c] && (!found || sqd[c] < sqd[best])) begin
                        best  = c;
                        found = 1;
                    end
                end
                taken[best] = 1;
                p.id   = 6'(best);
                p.sqd  = 38'(sqd[best]);
                p.last = (k + 1 == np);
                pending.insert(pending.size(), p);
            end
        endfunction

        function void check_result(logic [5:0] id, logic [37:0] sqd, logic last);
            probe_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word id=%0d sq_distance=%0d", id, sqd);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (id !== e.id) begin
                $error("m_probe_id expected %0d actual %0d", e.id, id);
                errors++;
            end
            if (sqd !== e.sqd) begin
                $error("sq_distance expected %0d actual %0d", e.sqd, sqd);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_result expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_cmd = 0;
    logic [5:0]         s_centroid_index = 0;
    logic [5:0]         s_coord_index = 0;
    logic signed [15:0] s_coord_value = 0;
    logic               s_last_coord = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [5:0]         m_probe_id;
    logic [37:0]        m_sq_distance;
    logic               m_last_result;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 0;
    logic [6:0]         cfg_data = 0;

    probe_scoreboard sb = new();
    int  send_idle  = 0;
    int  recv_stall = 0;
    int  hold_len   = 0;
    bit  written[64][64];

    nearest_centroid_probe_select_core u_dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Drive m_ready and check each accepted result word.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_probe_id, m_sq_distance, m_last_result);
            if (hold_len > 0) begin
                hold_len--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Offer one coordinate word and hold it until accepted, then maybe idle.
    task automatic send_word(logic cmd, logic [5:0] ci, logic [5:0] di,
                             logic signed [15:0] val, logic last);
        s_valid          <= 1;
        s_cmd            <= cmd;
        s_centroid_index <= ci;
        s_coord_index    <= di;
        s_coord_value    <= val;
        s_last_coord     <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(cmd, ci, di, val, last);
        if (cmd == ncps_pkg::CMD_CENTROID)
            written[ci][di] = 1;
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
    endtask

    // Write all three registers back to back.
    task automatic set_config(logic [6:0] nc, logic [6:0] nd, logic [6:0] np);
        logic [6:0] vals[3];
        logic [1:0] idx[3];
        vals = '{nc, nd, np};
        idx  = '{ncps_pkg::REG_CENTROIDS, ncps_pkg::REG_DIMS, ncps_pkg::REG_PROBES};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_valid <= 0;
    endtask

    // Stop offering and wait for every expected result, then let the core settle.
    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0:       return 16'(int'($urandom_range(4)) - 2);
            1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send a full query vector with the final mark on the last coordinate.
    task automatic send_query(int nd);
        for (int d = 0; d < nd; d++)
            send_word(ncps_pkg::CMD_QUERY, 6'($urandom), 6'(d), rand_coord(), d == nd - 1);
    endtask

    int unsigned ph_nc[8] = '{4, 64, 1, 0, 6, 127, 8, 3};
    int unsigned ph_nd[8] = '{4, 1, 64, 2, 3, 1, 5, 0};
    int unsigned ph_np[8] = '{8, 64, 127, 0, 3, 40, 5, 2};
    int          eff_nc, eff_nd, pick;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 87; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 87; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            set_config(7'(ph_nc[ph]), 7'(ph_nd[ph]), 7'(ph_np[ph]));
            eff_nc = (ph_nc[ph] < 1) ? 1 : (ph_nc[ph] > 64) ? 64 : ph_nc[ph];
            eff_nd = (ph_nd[ph] < 1) ? 1 : (ph_nd[ph] > 64) ? 64 : ph_nd[ph];
            if (ph == 0) begin
                // Full-scale extremes, and two equal centroids to force a tie.
                for (int d = 0; d < 4; d++) begin
                    send_word(ncps_pkg::CMD_CENTROID, 6'd0, 6'(d), 16'sh7fff, 1'b1);
                    send_word(ncps_pkg::CMD_CENTROID, 6'd1, 6'(d), 16'sh8000, 1'b0);
                    send_word(ncps_pkg::CMD_CENTROID, 6'd2, 6'(d), 16'sh0000, 1'b0);
                    send_word(ncps_pkg::CMD_CENTROID, 6'd3, 6'(d), 16'sh0000, 1'b1);
                end
                for (int d = 0; d < 4; d++)
                    send_word(ncps_pkg::CMD_QUERY, 6'd0, 6'(d), 16'sh8000, d == 3);
                for (int d = 0; d < 4; d++)
                    send_word(ncps_pkg::CMD_QUERY, 6'd63, 6'(d), 16'sh7fff, d == 3);
            end
            // Fill every active table entry not yet loaded.
            for (int c = 0; c < eff_nc; c++)
                for (int d = 0; d < eff_nd; d++)
                    if (!written[c][d])
                        send_word(ncps_pkg::CMD_CENTROID, 6'(c), 6'(d), rand_coord(),
                                  1'($urandom_range(1)));
            // Hold the receiver off while queries keep coming.
            if (ph == 4) begin
                hold_len = 300;
                send_query(eff_nd);
                send_query(eff_nd);
            end
            if (eff_nd > 16)
                send_query(eff_nd);
            else
                for (int k = 0; k < 2; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 25)
                        send_word(ncps_pkg::CMD_CENTROID, 6'($urandom), 6'($urandom),
                                  rand_coord(), 1'($urandom_range(1)));
                    else if (pick < 40)
                        send_word(ncps_pkg::CMD_QUERY, 6'($urandom), 6'($urandom),
                                  rand_coord(), 1'b0);
                    else
                        send_query(eff_nd);
                end
            drain();
        end
        if (sb.pending.size() != 0) begin
            $error("%0d expected result words never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
